@@ rtl/core/nearest_points_centroid_distance_macros.svh @@
// Assertion macros shared by the nearest points centroid distance RTL.
`ifndef NEAREST_POINTS_CENTROID_DISTANCE_MACROS_SVH
`define NEAREST_POINTS_CENTROID_DISTANCE_MACROS_SVH

`ifndef SYNTH
`define NPCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NPCD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NPCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define NPCD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

@@ rtl/core/npcd_pkg.sv @@
// ----------------------------------------------------------------------------
// npcd_pkg
// Types and constants shared by the nearest points centroid distance block.
// ----------------------------------------------------------------------------
package npcd_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIST_W    = 32;
	localparam int RNG_W     = 7;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int SQ_W      = 64;

	localparam logic [OP_W-1:0] OP_LOAD_FUSED  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SENSOR = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_FUSED_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_SENSOR_EMPTY = 2'd2;

	localparam logic [RNG_W-1:0] RNG_RESET = 7'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] ref_x;
		logic signed [COORD_W-1:0] ref_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic signed [COORD_W-1:0] time_delta;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [STAT_W-1:0] status;
	} out_item_t;

	typedef struct packed {
		logic load_fused;
		logic load_sensor;
		logic clear;
		logic start;
		logic poly;
	} knn_cmd_t;

	typedef enum logic [1:0] {
		KN_IDLE,
		KN_NU,
		KN_SCAN,
		KN_NEXT
	} kn_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_FUSED,
		T_DIV_FX,
		T_DIV_FY,
		T_SENSOR,
		T_DIV_SX,
		T_DIV_SY,
		T_SHIFT,
		T_DIFF,
		T_SQUARE,
		T_SUM,
		T_SQRT,
		T_FIN
	} top_state_t;

endpackage

@@ rtl/core/npcd_knn.sv @@
// ----------------------------------------------------------------------------
// npcd_knn
// Point stores of both polygons and the nearest point selection engine.
// Each pass scans the store through a four stage pipeline and picks the
// next nearest point after the one picked in the pass before.
// ----------------------------------------------------------------------------
module npcd_knn import npcd_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int SW = COORD_W + AW + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  knn_cmd_t                  cmd,
	input  logic signed [COORD_W-1:0] load_x,
	input  logic signed [COORD_W-1:0] load_y,
	input  logic signed [COORD_W-1:0] ref_x,
	input  logic signed [COORD_W-1:0] ref_y,
	input  logic [RNG_W-1:0]          rng,
	output logic                      done,
	output logic [CW-1:0]             fused_cnt,
	output logic [CW-1:0]             sensor_cnt,
	output logic [CW-1:0]             nu,
	output logic signed [SW-1:0]      sum_x,
	output logic signed [SW-1:0]      sum_y
);

	localparam int DW = COORD_W + 1;
	localparam int KW = 2 * DW;
	localparam int NW = ((CW > RNG_W) ? CW : RNG_W) + 1;
	localparam int PW = 2 * COORD_W;

	logic [PW-1:0] mem_f [MAX_POINTS];
	logic [PW-1:0] mem_s [MAX_POINTS];

	kn_state_t state_q, state_d;
	logic [CW-1:0] fcnt_q, scnt_q, cnt_q, rem_q, quo_q, nu_q, pass_q, j_q;
	logic poly_q;
	logic [RNG_W-1:0] rng_eff;
	logic [NW-1:0] q1, mx, nu_w;
	logic issue, pass_end, nu_done;

	logic [PW-1:0] rdf_s1, rds_s1, pt_s2, pt_s3;
	logic v_s1, v_s2, v_s3;
	logic [CW-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] ax_s2, ay_s2;
	logic [KW-1:0] sqx_s3, sqy_s3, key;
	logic cand, better;

	logic [KW-1:0] best_key_q, prev_key_q;
	logic [CW-1:0] best_idx_q, prev_idx_q;
	logic [PW-1:0] best_pt_q;
	logic best_vld_q, prev_vld_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q;
	logic done_q;

	assign rng_eff = (rng == '0) ? RNG_W'(1) : rng;

	assign q1   = NW'(quo_q) + NW'(1);
	assign mx   = (NW'(rng_eff) > q1) ? NW'(rng_eff) : q1;
	assign nu_w = (NW'(cnt_q) < mx) ? NW'(cnt_q) : mx;
	assign nu_done = NW'(rem_q) < NW'(rng_eff);

	always_ff @(posedge clk) begin
		if (cmd.load_fused && fcnt_q < CW'(MAX_POINTS)) begin
			mem_f[fcnt_q[AW-1:0]] <= {load_x, load_y};
		end
		if (cmd.load_sensor && scnt_q < CW'(MAX_POINTS)) begin
			mem_s[scnt_q[AW-1:0]] <= {load_x, load_y};
		end
		rdf_s1 <= mem_f[j_q[AW-1:0]];
		rds_s1 <= mem_s[j_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			scnt_q <= '0;
		end else if (cmd.clear) begin
			fcnt_q <= '0;
			scnt_q <= '0;
		end else begin
			if (cmd.load_fused && fcnt_q < CW'(MAX_POINTS)) begin
				fcnt_q <= fcnt_q + CW'(1);
			end
			if (cmd.load_sensor && scnt_q < CW'(MAX_POINTS)) begin
				scnt_q <= scnt_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KN_IDLE: begin
				if (cmd.start) begin
					state_d = KN_NU;
				end
			end
			KN_NU: begin
				if (nu_done) begin
					state_d = KN_SCAN;
				end
			end
			KN_SCAN: begin
				if (pass_end) begin
					state_d = KN_NEXT;
				end
			end
			KN_NEXT: begin
				state_d = (pass_q + CW'(1) == nu_q) ? KN_IDLE : KN_SCAN;
			end
			default: state_d = KN_IDLE;
		endcase
	end

	always_comb begin
		issue    = 1'b0;
		pass_end = 1'b0;
		unique case (state_q)
			KN_SCAN: begin
				issue    = j_q < cnt_q;
				pass_end = (j_q == cnt_q) && !v_s1 && !v_s2 && !v_s3;
			end
			default: begin
				issue    = 1'b0;
				pass_end = 1'b0;
			end
		endcase
	end

	assign dx = poly_q ? (DW'($signed(rds_s1[PW-1:COORD_W])) - DW'(ref_x))
	                   : (DW'($signed(rdf_s1[PW-1:COORD_W])) - DW'(ref_x));
	assign dy = poly_q ? (DW'($signed(rds_s1[COORD_W-1:0])) - DW'(ref_y))
	                   : (DW'($signed(rdf_s1[COORD_W-1:0])) - DW'(ref_y));

	assign key    = sqx_s3 + sqy_s3;
	assign cand   = !prev_vld_q || (key > prev_key_q) ||
	                ((key == prev_key_q) && (idx_s3 > prev_idx_q));
	assign better = !best_vld_q || (key < best_key_q);

	always_ff @(posedge clk) begin
		idx_s1 <= j_q;
		pt_s2  <= poly_q ? rds_s1 : rdf_s1;
		ax_s2  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay_s2  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
		idx_s2 <= idx_s1;
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
		pt_s3  <= pt_s2;
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= KN_IDLE;
			poly_q     <= 1'b0;
			cnt_q      <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			nu_q       <= '0;
			pass_q     <= '0;
			j_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			best_vld_q <= 1'b0;
			prev_vld_q <= 1'b0;
			best_key_q <= '0;
			prev_key_q <= '0;
			best_idx_q <= '0;
			prev_idx_q <= '0;
			best_pt_q  <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			done_q  <= 1'b0;
			if (issue) begin
				j_q <= j_q + CW'(1);
			end
			if (v_s3 && cand && better) begin
				best_key_q <= key;
				best_idx_q <= idx_s3;
				best_pt_q  <= pt_s3;
				best_vld_q <= 1'b1;
			end
			unique case (state_q)
				KN_IDLE: begin
					if (cmd.start) begin
						poly_q <= cmd.poly;
						cnt_q  <= cmd.poly ? scnt_q : fcnt_q;
						rem_q  <= cmd.poly ? scnt_q : fcnt_q;
						quo_q  <= '0;
					end
				end
				KN_NU: begin
					if (nu_done) begin
						nu_q       <= nu_w[CW-1:0];
						pass_q     <= '0;
						j_q        <= '0;
						best_vld_q <= 1'b0;
						prev_vld_q <= 1'b0;
						sum_x_q    <= '0;
						sum_y_q    <= '0;
					end else begin
						rem_q <= rem_q - CW'(rng_eff);
						quo_q <= quo_q + CW'(1);
					end
				end
				KN_NEXT: begin
					sum_x_q    <= sum_x_q + SW'($signed(best_pt_q[PW-1:COORD_W]));
					sum_y_q    <= sum_y_q + SW'($signed(best_pt_q[COORD_W-1:0]));
					prev_key_q <= best_key_q;
					prev_idx_q <= best_idx_q;
					prev_vld_q <= 1'b1;
					best_vld_q <= 1'b0;
					pass_q     <= pass_q + CW'(1);
					j_q        <= '0;
					done_q     <= (pass_q + CW'(1) == nu_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign done       = done_q;
	assign fused_cnt  = fcnt_q;
	assign sensor_cnt = scnt_q;
	assign nu         = nu_q;
	assign sum_x      = sum_x_q;
	assign sum_y      = sum_y_q;

endmodule

@@ rtl/core/npcd_div.sv @@
// ----------------------------------------------------------------------------
// npcd_div
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero.
// ----------------------------------------------------------------------------
module npcd_div import npcd_pkg::*; #(
	parameter int NUM_W = 39,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo
);

	localparam int IW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] dvd_q, num_mag;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [DEN_W:0] r;
	logic [IW-1:0] cnt_q;
	logic busy_q, neg_q, done_q, qbit;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign r       = {rem_q, dvd_q[NUM_W-1]};
	assign qbit    = r >= (DEN_W+1)'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			dvd_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= IW'(NUM_W);
				neg_q  <= num[NUM_W-1];
				dvd_q  <= num_mag + NUM_W'(den >> 1);
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q  <= qbit ? DEN_W'(r - (DEN_W+1)'(den_q)) : r[DEN_W-1:0];
				dvd_q  <= {dvd_q[NUM_W-2:0], qbit};
				cnt_q  <= cnt_q - IW'(1);
				if (cnt_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

@@ rtl/core/npcd_sqrt.sv @@
// ----------------------------------------------------------------------------
// npcd_sqrt
// Digit by digit square root, one result bit per cycle, rounded to nearest
// and saturated to the distance width.
// ----------------------------------------------------------------------------
module npcd_sqrt import npcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [DIST_W-1:0] root
);

	localparam int RW = DIST_W + 2;
	localparam int IW = $clog2(DIST_W + 1);

	logic [SQ_W-1:0] s_q;
	logic [RW-1:0] rem_q;
	logic [DIST_W-1:0] root_q, res_q;
	logic [RW+1:0] r, trial;
	logic [DIST_W:0] rounded;
	logic [IW-1:0] cnt_q;
	logic busy_q, fin_q, done_q, take;

	assign r       = {rem_q, s_q[SQ_W-1:SQ_W-2]};
	assign trial   = (RW+2)'({root_q, 2'b01});
	assign take    = r >= trial;
	assign rounded = (rem_q > RW'(root_q)) ? ((DIST_W+1)'(root_q) + (DIST_W+1)'(1))
	                                       : (DIST_W+1)'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			s_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= IW'(DIST_W);
				s_q    <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q  <= take ? RW'(r - trial) : RW'(r);
				root_q <= {root_q[DIST_W-2:0], take};
				s_q    <= {s_q[SQ_W-3:0], 2'b00};
				cnt_q  <= cnt_q - IW'(1);
				if (cnt_q == IW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				res_q  <= (rounded >= (DIST_W+1)'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
				                                                    : rounded[DIST_W-1:0];
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule

@@ rtl/core/nearest_points_centroid_distance.sv @@
// ----------------------------------------------------------------------------
// nearest_points_centroid_distance
// Distance between the nearest point centroids of a fused and a sensor
// polygon, with the fused centroid moved by velocity times time difference.
//
//   channel   direction  signals
//   item      in         item_valid, item_ready, item
//   result    out        result_valid, result_ready, result
//   config    in         cfg_wr_en, cfg_wr_data
//
// Loads may follow each other every cycle while the block is idle.
// A compute transfer runs the point selection and two divisions for each
// polygon in turn, then the shift, difference, square and sum steps, the
// square root and the result register. A compute with an empty polygon goes
// straight to the result register.
// The result register frees the next item while a result waits to be taken.
// Reset clears both point counts and sets the range to three.
// ----------------------------------------------------------------------------
`include "nearest_points_centroid_distance_macros.svh"

module nearest_points_centroid_distance import npcd_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             cfg_wr_en,
	input  logic [RNG_W-1:0] cfg_wr_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = COORD_W + AW + 1;
	localparam int FW = COORD_W + 1;
	localparam int PW = 2 * COORD_W;
	localparam int HW = PW - FRAC_BITS + 1;
	localparam int EW = PW - FRAC_BITS + 3;
	localparam int XW = (EW > DIST_W + 1) ? EW : DIST_W + 1;

	top_state_t state_q, state_d;
	logic go_q;
	logic [RNG_W-1:0] rng_q;
	logic signed [COORD_W-1:0] ref_x_q, ref_y_q, vel_x_q, vel_y_q, dt_q;
	logic signed [FW-1:0] fx_q, fy_q, sxc_q, syc_q;
	logic [PW-1:0] px_q, py_q;
	logic negx_q, negy_q, ovf_q;
	logic [DIST_W-1:0] ax_q, ay_q;
	logic [SQ_W-1:0] sqx_q, sqy_q;
	logic [SQ_W:0] sumsq_q;
	logic [STAT_W-1:0] status_q;
	out_item_t out_q;
	logic out_valid_q;

	logic accept, finish;
	knn_cmd_t cmd;
	logic knn_done, div_done, sqrt_done, div_start;
	logic [CW-1:0] fused_cnt, sensor_cnt, nu;
	logic signed [SW-1:0] sum_x, sum_y, div_num, quo;
	logic [DIST_W-1:0] root;
	logic [HW-1:0] shx, shy;
	logic signed [EW-1:0] dx, dy;
	logic [XW-1:0] adx, ady;

	function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
		return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
	endfunction

	assign item_ready = state_q == T_IDLE;
	assign accept     = item_valid && item_ready;
	assign finish     = (state_q == T_FIN) && (!out_valid_q || result_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (accept && item.op == OP_COMPUTE) begin
					state_d = (fused_cnt == '0 || sensor_cnt == '0) ? T_FIN : T_FUSED;
				end
			end
			T_FUSED:  if (knn_done) state_d = T_DIV_FX;
			T_DIV_FX: if (div_done) state_d = T_DIV_FY;
			T_DIV_FY: if (div_done) state_d = T_SENSOR;
			T_SENSOR: if (knn_done) state_d = T_DIV_SX;
			T_DIV_SX: if (div_done) state_d = T_DIV_SY;
			T_DIV_SY: if (div_done) state_d = T_SHIFT;
			T_SHIFT:  state_d = T_DIFF;
			T_DIFF:   state_d = T_SQUARE;
			T_SQUARE: state_d = T_SUM;
			T_SUM:    state_d = T_SQRT;
			T_SQRT:   if (sqrt_done) state_d = T_FIN;
			T_FIN:    if (finish) state_d = T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	always_comb begin
		cmd.load_fused  = accept && item.op == OP_LOAD_FUSED;
		cmd.load_sensor = accept && item.op == OP_LOAD_SENSOR;
		cmd.clear       = finish;
		cmd.start       = 1'b0;
		cmd.poly        = 1'b0;
		div_start       = 1'b0;
		div_num         = sum_x;
		unique case (state_q)
			T_FUSED:  cmd.start = go_q;
			T_SENSOR: begin
				cmd.start = go_q;
				cmd.poly  = 1'b1;
			end
			T_DIV_FX, T_DIV_SX: begin
				div_start = go_q;
				div_num   = sum_x;
			end
			T_DIV_FY, T_DIV_SY: begin
				div_start = go_q;
				div_num   = sum_y;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	assign shx = HW'((px_q + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign shy = HW'((py_q + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign dx  = EW'(fx_q) + (negx_q ? -$signed(EW'(shx)) : $signed(EW'(shx))) - EW'(sxc_q);
	assign dy  = EW'(fy_q) + (negy_q ? -$signed(EW'(shy)) : $signed(EW'(shy))) - EW'(syc_q);
	assign adx = dx[EW-1] ? XW'(-dx) : XW'(dx);
	assign ady = dy[EW-1] ? XW'(-dy) : XW'(dy);

	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				if (accept && item.op == OP_COMPUTE) begin
					ref_x_q <= item.ref_x;
					ref_y_q <= item.ref_y;
					vel_x_q <= item.vel_x;
					vel_y_q <= item.vel_y;
					dt_q    <= item.time_delta;
				end
			end
			T_DIV_FX: if (div_done) fx_q  <= quo[FW-1:0];
			T_DIV_FY: if (div_done) fy_q  <= quo[FW-1:0];
			T_DIV_SX: if (div_done) sxc_q <= quo[FW-1:0];
			T_DIV_SY: if (div_done) syc_q <= quo[FW-1:0];
			T_SHIFT: begin
				px_q   <= mag(vel_x_q) * mag(dt_q);
				py_q   <= mag(vel_y_q) * mag(dt_q);
				negx_q <= vel_x_q[COORD_W-1] != dt_q[COORD_W-1];
				negy_q <= vel_y_q[COORD_W-1] != dt_q[COORD_W-1];
			end
			T_DIFF: begin
				ax_q  <= adx[DIST_W-1:0];
				ay_q  <= ady[DIST_W-1:0];
				ovf_q <= (|adx[XW-1:DIST_W]) || (|ady[XW-1:DIST_W]);
			end
			T_SQUARE: begin
				sqx_q <= ax_q * ax_q;
				sqy_q <= ay_q * ay_q;
			end
			T_SUM: sumsq_q <= (SQ_W+1)'(sqx_q) + (SQ_W+1)'(sqy_q);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			go_q        <= 1'b0;
			rng_q       <= RNG_RESET;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			go_q    <= state_d != state_q;
			if (cfg_wr_en) begin
				rng_q <= cfg_wr_data;
			end
			if (accept && item.op == OP_COMPUTE) begin
				status_q <= (fused_cnt == '0) ? ST_FUSED_EMPTY :
				            (sensor_cnt == '0) ? ST_SENSOR_EMPTY : ST_OK;
			end
			if (finish) begin
				out_valid_q    <= 1'b1;
				out_q.status   <= status_q;
				out_q.distance <= (status_q != ST_OK || ovf_q || sumsq_q[SQ_W])
				                  ? {DIST_W{1'b1}} : root;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	npcd_knn #(
		.MAX_POINTS(MAX_POINTS),
		.AW(AW),
		.CW(CW),
		.SW(SW)
	) u_knn (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.load_x(item.point_x),
		.load_y(item.point_y),
		.ref_x(ref_x_q),
		.ref_y(ref_y_q),
		.rng(rng_q),
		.done(knn_done),
		.fused_cnt(fused_cnt),
		.sensor_cnt(sensor_cnt),
		.nu(nu),
		.sum_x(sum_x),
		.sum_y(sum_y)
	);

	npcd_div #(
		.NUM_W(SW),
		.DEN_W(CW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(nu),
		.done(div_done),
		.quo(quo)
	);

	npcd_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(go_q && state_q == T_SQRT),
		.radicand(sumsq_q[SQ_W-1:0]),
		.done(sqrt_done),
		.root(root)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`NPCD_ASSERT(a_empty_sat, clk, arst_n, !(result_valid && result.status != ST_OK) || result.distance == {DIST_W{1'b1}}, "Empty polygon result without saturated distance.")
	`NPCD_ASSERT_NEXT(a_clear, clk, arst_n, finish, fused_cnt == '0 && sensor_cnt == '0, "Point counts not cleared after compute.")
	`NPCD_ASSERT(a_start_busy, clk, arst_n, !cmd.start || state_q == T_FUSED || state_q == T_SENSOR, "Selection started outside a selection state.")

endmodule

@@ tb/tb_nearest_points_centroid_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_points_centroid_distance
// Loads random fused and sensor polygons and issues compute transfers under
// several range settings, with random idle bursts on both channels. Each
// distance and status is checked against a centroid and distance predictor
// kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_nearest_points_centroid_distance;
	import npcd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int NPTS = 64;
	localparam logic [DIST_W-1:0] DIST_SAT = '1;
	localparam longint CYCLE_LIMIT = 4000000;

	class centroid_scoreboard;
		longint px[2][NPTS];
		longint py[2][NPTS];
		int cnt[2];
		int rng;
		out_item_t dist_q[$];
		int mismatches;
		int fails;

		function void clear();
			cnt[0] = 0;
			cnt[1] = 0;
			rng = RNG_RESET;
			mismatches = 0;
			fails = 0;
		endfunction

		function automatic logic [65:0] sqdist(longint ax, longint ay, longint rx, longint ry);
			longint dx;
			longint dy;
			logic [65:0] mx;
			logic [65:0] my;
			dx = ax - rx;
			dy = ay - ry;
			mx = dx < 0 ? -dx : dx;
			my = dy < 0 ? -dy : dy;
			return mx * mx + my * my;
		endfunction

		function automatic longint round_div(longint s, longint n);
			if (s >= 0)
				return (s + n / 2) / n;
			return -((-s + n / 2) / n);
		endfunction

		function automatic bit centroid(int s, longint rx, longint ry,
				output longint cx, output longint cy);
			int r;
			int nu;
			int rank;
			longint sx;
			longint sy;
			logic [65:0] di;
			logic [65:0] dj;
			cx = 0;
			cy = 0;
			if (cnt[s] == 0)
				return 0;
			r = rng ? rng : 1;
			nu = cnt[s] / r + 1;
			if (r > nu)
				nu = r;
			if (cnt[s] < nu)
				nu = cnt[s];
			sx = 0;
			sy = 0;
			for (int i = 0; i < cnt[s]; i++) begin
				rank = 0;
				di = sqdist(px[s][i], py[s][i], rx, ry);
				for (int j = 0; j < cnt[s]; j++) begin
					if (j == i)
						continue;
					dj = sqdist(px[s][j], py[s][j], rx, ry);
					if (dj < di || (dj == di && j < i))
						rank++;
				end
				if (rank < nu) begin
					sx += px[s][i];
					sy += py[s][i];
				end
			end
			cx = round_div(sx, nu);
			cy = round_div(sy, nu);
			return 1;
		endfunction

		function automatic longint vel_shift(longint v, longint dt);
			logic [63:0] mv;
			logic [63:0] md;
			logic [63:0] p;
			longint sh;
			mv = v < 0 ? -v : v;
			md = dt < 0 ? -dt : dt;
			p = mv * md;
			sh = longint'((p + 64'h8000) >> 16);
			return ((v < 0) != (dt < 0)) ? -sh : sh;
		endfunction

		function automatic logic [DIST_W-1:0] planar(longint dx, longint dy);
			logic [65:0] mx;
			logic [65:0] my;
			logic [65:0] s;
			logic [63:0] t;
			logic [63:0] root;
			mx = dx < 0 ? -dx : dx;
			my = dy < 0 ? -dy : dy;
			if (mx >= 66'h1_0000_0000 || my >= 66'h1_0000_0000)
				return DIST_SAT;
			s = mx * mx + my * my;
			if (s[65:64] != 0)
				return DIST_SAT;
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				t = root | (64'd1 << b);
				if (t * t <= s[63:0])
					root = t;
			end
			if (s[63:0] - root * root > root)
				root++;
			if (root >= 64'hFFFF_FFFF)
				return DIST_SAT;
			return root[DIST_W-1:0];
		endfunction

		function void note_input(in_item_t it);
			int s;
			longint rx;
			longint ry;
			longint fx;
			longint fy;
			longint sx;
			longint sy;
			out_item_t e;
			if (it.op == OP_LOAD_FUSED || it.op == OP_LOAD_SENSOR) begin
				s = (it.op == OP_LOAD_FUSED) ? 0 : 1;
				if (cnt[s] < NPTS) begin
					px[s][cnt[s]] = longint'(it.point_x);
					py[s][cnt[s]] = longint'(it.point_y);
					cnt[s]++;
				end
				return;
			end
			if (it.op != OP_COMPUTE)
				return;
			rx = longint'(it.ref_x);
			ry = longint'(it.ref_y);
			e.distance = DIST_SAT;
			if (!centroid(0, rx, ry, fx, fy)) begin
				e.status = ST_FUSED_EMPTY;
			end else if (!centroid(1, rx, ry, sx, sy)) begin
				e.status = ST_SENSOR_EMPTY;
			end else begin
				e.status = ST_OK;
				fx += vel_shift(longint'(it.vel_x), longint'(it.time_delta));
				fy += vel_shift(longint'(it.vel_y), longint'(it.time_delta));
				e.distance = planar(fx - sx, fy - sy);
			end
			cnt[0] = 0;
			cnt[1] = 0;
			dist_q.insert(dist_q.size(), e);
		endfunction

		function void check_result(out_item_t r);
			out_item_t e;
			if (dist_q.size() == 0) begin
				fails++;
				if (mismatches++ < 10)
					$display("Unexpected result: distance %h status %0d", r.distance, r.status);
				return;
			end
			e = dist_q.pop_front();
			if (r.distance !== e.distance || r.status !== e.status) begin
				fails++;
				if (mismatches++ < 10)
					$display("Mismatch: expected distance %h status %0d, got %h status %0d",
						e.distance, e.status, r.distance, r.status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_item_t item;
	logic result_valid;
	logic result_ready;
	out_item_t result;
	logic cfg_wr_en;
	logic [RNG_W-1:0] cfg_wr_data;

	centroid_scoreboard sb;
	bit quiet;
	bit sink_on;
	longint cycles;
	int items_sent;

	nearest_points_centroid_distance uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_input(item);
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	initial begin
		result_ready = 0;
		wait (sink_on);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result_ready <= 0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			result_ready <= 1;
		end
	end

	function automatic logic [COORD_W-1:0] rand_coord(logic [COORD_W-1:0] near);
		case ($urandom_range(0, 4))
			0, 1: return $urandom;
			2: return near + (($urandom_range(0, 255) - 128) << 12);
			3: return near;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	// with valid still high, so the next item can follow without a gap.
	task automatic send(in_item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_op(logic [OP_W-1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		in_item_t it;
		it.op = op;
		it.point_x = x;
		it.point_y = y;
		it.ref_x = $urandom;
		it.ref_y = $urandom;
		it.vel_x = $urandom;
		it.vel_y = $urandom;
		it.time_delta = $urandom;
		send(it);
	endtask

	task automatic send_compute(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry,
			logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy, logic [COORD_W-1:0] dt);
		in_item_t it;
		it.op = OP_COMPUTE;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.ref_x = rx;
		it.ref_y = ry;
		it.vel_x = vx;
		it.vel_y = vy;
		it.time_delta = dt;
		send(it);
	endtask

	task automatic random_round();
		int nf;
		int ns;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] dt;
		cx = $urandom_range(0, 3) == 0 ? $urandom : (($urandom_range(0, 2047) - 1024) << 14);
		cy = $urandom_range(0, 3) == 0 ? $urandom : (($urandom_range(0, 2047) - 1024) << 14);
		nf = $urandom_range(0, 40) == 0 ? $urandom_range(0, 70) : $urandom_range(0, 8);
		ns = $urandom_range(0, 40) == 0 ? $urandom_range(0, 70) : $urandom_range(0, 8);
		while (nf > 0 || ns > 0) begin
			if ($urandom_range(0, 30) == 0)
				send_op(OP_UNUSED, $urandom, $urandom);
			else if (nf > 0 && (ns == 0 || $urandom_range(0, 1))) begin
				send_op(OP_LOAD_FUSED, rand_coord(cx), rand_coord(cy));
				nf--;
			end else begin
				send_op(OP_LOAD_SENSOR, rand_coord(cx), rand_coord(cy));
				ns--;
			end
		end
		dt = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h3_0000) - 32'h1_8000;
		send_compute(rand_coord(cx), rand_coord(cy),
			$urandom_range(0, 2) == 0 ? $urandom : ($urandom_range(0, 4095) - 2048) << 12,
			$urandom_range(0, 2) == 0 ? $urandom : ($urandom_range(0, 4095) - 2048) << 12, dt);
	endtask

	task automatic drain();
		item_valid <= 0;
		while (sb.dist_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_range(logic [RNG_W-1:0] r);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= r;
		sb.rng = r;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	initial begin
		logic [RNG_W-1:0] ranges[7];
		sb = new();
		sb.clear();
		cycles = 0;
		items_sent = 0;
		quiet = 0;
		sink_on = 0;
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		sink_on = 1;

		// Both polygons empty, then sensor polygon empty, then an unused op.
		send_compute(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_op(OP_LOAD_FUSED, 32'h0001_0000, 32'h0002_0000);
		send_compute(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_op(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000);
		// Opposite corners saturate the distance.
		send_op(OP_LOAD_FUSED, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_LOAD_SENSOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_compute(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		// Equal distances resolve toward the lower index.
		send_op(OP_LOAD_FUSED, 32'h0001_0000, 32'h0);
		send_op(OP_LOAD_FUSED, 32'hFFFF_0000, 32'h0);
		send_op(OP_LOAD_FUSED, 32'h0, 32'h0001_0000);
		send_op(OP_LOAD_FUSED, 32'h0, 32'hFFFF_0000);
		send_op(OP_LOAD_SENSOR, 32'h0001_0000, 32'h0001_0000);
		send_op(OP_LOAD_SENSOR, 32'h0001_0000, 32'h0001_0000);
		send_compute(32'h0, 32'h0, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_8001);
		// Extreme velocity and time difference.
		send_op(OP_LOAD_FUSED, 32'h0, 32'h0);
		send_op(OP_LOAD_SENSOR, 32'h0, 32'h0);
		send_compute(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_op(OP_LOAD_FUSED, 32'h0000_0003, 32'hFFFF_FFFD);
		send_op(OP_LOAD_SENSOR, 32'h0, 32'h0);
		send_compute(32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000);

		ranges = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd3};
		while (items_sent < 250)
			random_round();
		foreach (ranges[k]) begin
			write_range(ranges[k] == 7'd2 ? RNG_W'($urandom_range(2, 10)) : ranges[k]);
			if (k == 6)
				quiet = 1;
			while (items_sent < 250 + (k + 1) * 215)
				random_round();
		end

		drain();
		if (sb.dist_q.size() != 0)
			sb.fails++;
		if (sb.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/npcd_pkg.sv
rtl/core/npcd_knn.sv
rtl/core/npcd_div.sv
rtl/core/npcd_sqrt.sv
rtl/core/nearest_points_centroid_distance.sv
tb/tb_nearest_points_centroid_distance.sv
